@@ design/rpg_pkg.sv @@
// Shared types, constants and the color wheel function of the rainbow pattern generator.
`timescale 1ns / 1ps

package rpg_pkg;

  // Field widths of the words on the streams and the configuration port.
  localparam int MS_W       = 8;
  localparam int INTERVAL_W = 16;
  localparam int PIXCNT_W   = 7;
  localparam int PATTERN_W  = 2;
  localparam int IDX_W      = 6;
  localparam int COLOR_W    = 8;
  localparam int HUE_W      = 8;
  localparam int ELAPSED_W  = 17;
  localparam int SIZE_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_DATA_W = 32;

  // Strip length limit; the pixel index field holds indexes 0 to 63.
  localparam int MAX_PIXELS = 64;
  localparam int MIN_PIXELS = 2;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // Reset values of the configuration registers.
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd20;
  localparam logic [PIXCNT_W-1:0]   PIXCNT_RST   = 7'd64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXCNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN  = 2'd2;

  // Pattern codes as written to the pattern register.
  localparam logic [PATTERN_W-1:0] PAT_SPREAD = 2'd0;
  localparam logic [PATTERN_W-1:0] PAT_MIRROR = 2'd2;

  // Wheel segment bounds.
  localparam logic [HUE_W-1:0] SEG1 = 8'd85;
  localparam logic [HUE_W-1:0] SEG2 = 8'd170;
  localparam logic [COLOR_W-1:0] FULL = 8'd255;

  typedef enum logic [1:0] {
    MODE_SPREAD,
    MODE_PLAIN,
    MODE_MIRROR
  } mode_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_CALC,
    SEQ_DIV,
    SEQ_PUSH
  } seq_state_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  // Frame request from the timing front end to the sequencer.
  typedef struct packed {
    logic                start;
    logic [PIXCNT_W-1:0] n;
    mode_t               mode;
    logic [SIZE_W-1:0]   size;
  } frame_req_t;

  // Three-segment color wheel.
  function automatic rgb_t wheel(input logic [HUE_W-1:0] hue);
    rgb_t              c;
    logic [HUE_W-1:0]  h;
    logic [COLOR_W-1:0] h3;
    if (hue < SEG1) begin
      h = hue;
    end else if (hue < SEG2) begin
      h = hue - SEG1;
    end else begin
      h = hue - SEG2;
    end
    h3 = COLOR_W'({h, 1'b0}) + h;
    if (hue < SEG1) begin
      c.red   = h3;
      c.green = FULL - h3;
      c.blue  = '0;
    end else if (hue < SEG2) begin
      c.red   = FULL - h3;
      c.green = '0;
      c.blue  = h3;
    end else begin
      c.red   = '0;
      c.green = h3;
      c.blue  = FULL - h3;
    end
    return c;
  endfunction

endpackage

@@ design/rpg_divider.sv @@
// Bit-serial restoring divider that forms i*256/n, one quotient bit per cycle.
`timescale 1ns / 1ps

module rpg_divider (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [rpg_pkg::IDX_W-1:0]      numer,
  input  logic [rpg_pkg::PIXCNT_W-1:0]   denom,
  output logic                           done,
  output logic [rpg_pkg::HUE_W-1:0]      quot
);

  localparam int CNT_W = $clog2(rpg_pkg::HUE_W);

  logic                          busy_r;
  logic                          done_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [rpg_pkg::IDX_W-1:0]     rem_r;
  logic [rpg_pkg::PIXCNT_W-1:0]  den_r;
  logic [rpg_pkg::HUE_W-1:0]     q_r;

  logic [rpg_pkg::PIXCNT_W-1:0]  shifted;
  logic [rpg_pkg::PIXCNT_W-1:0]  diff;
  logic                          ge;

  // The remainder stays below n, so doubling it fits in seven bits.
  assign shifted = {rem_r, 1'b0};
  assign ge      = (shifted >= den_r);
  assign diff    = shifted - den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= numer;
        den_r  <= denom;
      end else if (busy_r) begin
        rem_r <= ge ? diff[rpg_pkg::IDX_W-1:0] : shifted[rpg_pkg::IDX_W-1:0];
        q_r   <= {q_r[rpg_pkg::HUE_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(rpg_pkg::HUE_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

@@ design/rpg_sequencer.sv @@
// Frame sequencer: walks the pixels of a frame, forms hues and holds the output word.
`timescale 1ns / 1ps

module rpg_sequencer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rpg_pkg::frame_req_t               req,
  output logic                              idle,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rpg_pkg::IDX_W-1:0]         out_idx,
  output rpg_pkg::rgb_t                     out_rgb,
  output logic                              out_tlast
);

  rpg_pkg::seq_state_t              state_r, state_nxt;
  logic [rpg_pkg::PIXCNT_W-1:0]     n_r, n_nxt;
  rpg_pkg::mode_t                   mode_r, mode_nxt;
  logic [rpg_pkg::SIZE_W-1:0]       size_r, size_nxt;
  logic [rpg_pkg::IDX_W-1:0]        i_r, i_nxt;
  logic                             second_r, second_nxt;
  logic [rpg_pkg::HUE_W-1:0]        hue_r, hue_nxt;
  logic [rpg_pkg::IDX_W-1:0]        idx_r, idx_nxt;
  logic [rpg_pkg::HUE_W-1:0]        phase_r, phase_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [rpg_pkg::IDX_W-1:0]        out_idx_r, out_idx_nxt;
  rpg_pkg::rgb_t                    out_rgb_r, out_rgb_nxt;
  logic                             out_last_r, out_last_nxt;

  logic                             div_start;
  logic                             div_done;
  logic [rpg_pkg::HUE_W-1:0]        div_quot;
  logic                             out_free;
  logic                             push_last;
  logic [rpg_pkg::IDX_W-1:0]        mirror_idx;

  rpg_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (i_r),
    .denom (n_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign out_free   = !out_valid_r || out_tready;
  assign mirror_idx = {size_r, 1'b0} - i_r;
  assign push_last  = (mode_r == rpg_pkg::MODE_MIRROR)
                    ? (second_r && (i_r == {1'b0, size_r - 1'b1}))
                    : ({1'b0, i_r} == n_r - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpg_pkg::SEQ_IDLE;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    mode_r     <= mode_nxt;
    size_r     <= size_nxt;
    i_r        <= i_nxt;
    second_r   <= second_nxt;
    hue_r      <= hue_nxt;
    idx_r      <= idx_nxt;
    out_idx_r  <= out_idx_nxt;
    out_rgb_r  <= out_rgb_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    mode_nxt      = mode_r;
    size_nxt      = size_r;
    i_nxt         = i_r;
    second_nxt    = second_r;
    hue_nxt       = hue_r;
    idx_nxt       = idx_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_idx_nxt   = out_idx_r;
    out_rgb_nxt   = out_rgb_r;
    out_last_nxt  = out_last_r;
    div_start     = 1'b0;

    unique case (state_r)
      rpg_pkg::SEQ_IDLE: begin
        if (req.start) begin
          n_nxt      = req.n;
          mode_nxt   = req.mode;
          size_nxt   = req.size;
          i_nxt      = '0;
          second_nxt = 1'b0;
          // A mirrored frame on a very short strip writes nothing but still advances.
          if ((req.mode == rpg_pkg::MODE_MIRROR) && (req.size == '0)) begin
            phase_nxt = phase_r + 1'b1;
          end else begin
            state_nxt = rpg_pkg::SEQ_CALC;
          end
        end
      end
      rpg_pkg::SEQ_CALC: begin
        idx_nxt = i_r;
        if (mode_r == rpg_pkg::MODE_SPREAD) begin
          div_start = 1'b1;
          state_nxt = rpg_pkg::SEQ_DIV;
        end else begin
          hue_nxt   = {2'b00, i_r} + phase_r;
          state_nxt = rpg_pkg::SEQ_PUSH;
        end
      end
      rpg_pkg::SEQ_DIV: begin
        if (div_done) begin
          hue_nxt   = div_quot + phase_r;
          state_nxt = rpg_pkg::SEQ_PUSH;
        end
      end
      rpg_pkg::SEQ_PUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = idx_r;
          out_rgb_nxt   = rpg_pkg::wheel(hue_r);
          out_last_nxt  = push_last;
          if ((mode_r == rpg_pkg::MODE_MIRROR) && !second_r) begin
            idx_nxt    = mirror_idx;
            second_nxt = 1'b1;
          end else if (push_last) begin
            phase_nxt = phase_r + 1'b1;
            state_nxt = rpg_pkg::SEQ_IDLE;
          end else begin
            i_nxt      = i_r + 1'b1;
            second_nxt = 1'b0;
            state_nxt  = rpg_pkg::SEQ_CALC;
          end
        end
      end
      default: begin
        state_nxt = rpg_pkg::SEQ_IDLE;
      end
    endcase
  end

  assign idle       = (state_r == rpg_pkg::SEQ_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_idx    = out_idx_r;
  assign out_rgb    = out_rgb_r;
  assign out_tlast  = out_last_r;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == rpg_pkg::SEQ_DIV))
    else $error("divider finished outside of the divide state");

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> (state_r == rpg_pkg::SEQ_IDLE))
    else $error("frame request while a frame is in progress");

  a_phase_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != $past(phase_r)) |-> (phase_r == $past(phase_r) + 1'b1))
    else $error("hue phase moved by other than one");

  a_last_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == rpg_pkg::SEQ_PUSH) && out_free && push_last
      && !((mode_r == rpg_pkg::MODE_MIRROR) && !second_r))
    |=> (state_r == rpg_pkg::SEQ_IDLE) && out_tlast && out_tvalid)
    else $error("frame end word did not close the frame");

endmodule

@@ design/rainbow_pattern_generator.sv @@
// Top level of the rainbow pattern generator: configuration, elapsed-time count and sequencer.
`timescale 1ns / 1ps

// Channel   Direction  Word contents (lowest bit first)              Handshake
// in_       slave      tdata: ms_passed[7:0]                         tvalid/tready
// out_      master     tdata: pixel_index, red, green, blue, 2 zero  tvalid/tready,
//                      bits; tlast: frame_end                        tlast
// cfg_      write      cfg_index selects the register, cfg_wdata     cfg_we
//
// An input word is taken whenever the sequencer is idle. A spread frame runs a calculation,
// a divide on the 8-step serial divider and a push per pixel, a plain frame a calculation and
// a push per pixel, and a mirrored pair one calculation and a push for each of its pixels;
// in_tready stays low until the last pixel is in the output register. Stalls on out_tready
// hold the sequencer in place. Reset is synchronous and active low; it restores the register
// defaults and clears the elapsed count and the hue phase. No clearing pass is needed.

module rainbow_pattern_generator (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // ms_passed[7:0]
  // Result stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rpg_pkg::OUT_DATA_W-1:0]    out_tdata,  // pixel_index[5:0], red[13:6],
                                                        // green[21:14], blue[29:22]
  output logic                              out_tlast,  // frame_end
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [rpg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rpg_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [rpg_pkg::INTERVAL_W-1:0] interval_r;
  logic [rpg_pkg::PIXCNT_W-1:0]   pixcnt_r;
  logic [rpg_pkg::PATTERN_W-1:0]  pattern_r;
  logic [rpg_pkg::ELAPSED_W-1:0]  elapsed_r, elapsed_nxt;

  logic                           in_accept;
  logic                           seq_idle;
  logic [rpg_pkg::ELAPSED_W:0]    sum_wide;
  logic [rpg_pkg::ELAPSED_W-1:0]  sum_sat;
  logic                           fire;
  logic [rpg_pkg::PIXCNT_W-1:0]   n_clamped;
  logic [rpg_pkg::PIXCNT_W-2:0]   half_minus;
  rpg_pkg::mode_t                 mode;
  rpg_pkg::frame_req_t            req;
  logic [rpg_pkg::IDX_W-1:0]      px_idx;
  rpg_pkg::rgb_t                  px_rgb;

  // The block takes a new time report only when no frame is being produced.
  assign in_tready = seq_idle;
  assign in_accept = in_tvalid && in_tready;

  // Registers are written whenever the enable is high; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= rpg_pkg::INTERVAL_RST;
      pixcnt_r   <= rpg_pkg::PIXCNT_RST;
      pattern_r  <= rpg_pkg::PAT_SPREAD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rpg_pkg::REG_INTERVAL: interval_r <= cfg_wdata;
        rpg_pkg::REG_PIXCNT:   pixcnt_r   <= cfg_wdata[rpg_pkg::PIXCNT_W-1:0];
        rpg_pkg::REG_PATTERN:  pattern_r  <= cfg_wdata[rpg_pkg::PATTERN_W-1:0];
        default: ;
      endcase
    end
  end

  // Elapsed time saturates at the top of its range. A frame fires when the
  // new count is strictly above the interval, and then the count restarts.
  assign sum_wide = {1'b0, elapsed_r} + (rpg_pkg::ELAPSED_W + 1)'(in_tdata);
  assign sum_sat  = sum_wide[rpg_pkg::ELAPSED_W] ? rpg_pkg::ELAPSED_MAX
                                                 : sum_wide[rpg_pkg::ELAPSED_W-1:0];
  assign fire     = in_accept && (sum_sat > {1'b0, interval_r});

  always_comb begin
    elapsed_nxt = elapsed_r;
    if (in_accept) begin
      elapsed_nxt = fire ? '0 : sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
    end else begin
      elapsed_r <= elapsed_nxt;
    end
  end

  // Strip length is held between two pixels and the strip limit.
  always_comb begin
    if (pixcnt_r < rpg_pkg::PIXCNT_W'(rpg_pkg::MIN_PIXELS)) begin
      n_clamped = rpg_pkg::PIXCNT_W'(rpg_pkg::MIN_PIXELS);
    end else if (pixcnt_r > rpg_pkg::PIXCNT_W'(rpg_pkg::MAX_PIXELS)) begin
      n_clamped = rpg_pkg::PIXCNT_W'(rpg_pkg::MAX_PIXELS);
    end else begin
      n_clamped = pixcnt_r;
    end
  end

  // Every pattern code other than spread and mirror behaves as the plain rainbow.
  always_comb begin
    if (pattern_r == rpg_pkg::PAT_SPREAD) begin
      mode = rpg_pkg::MODE_SPREAD;
    end else if (pattern_r == rpg_pkg::PAT_MIRROR) begin
      mode = rpg_pkg::MODE_MIRROR;
    end else begin
      mode = rpg_pkg::MODE_PLAIN;
    end
  end

  // Mirror half size is n/2 - 1; it is zero for strips shorter than four pixels.
  assign half_minus = n_clamped[rpg_pkg::PIXCNT_W-1:1] - 1'b1;

  always_comb begin
    req.start = fire;
    req.n     = n_clamped;
    req.mode  = mode;
    req.size  = (n_clamped < 7'd4) ? '0 : half_minus[rpg_pkg::SIZE_W-1:0];
  end

  rpg_sequencer u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .idle       (seq_idle),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_idx    (px_idx),
    .out_rgb    (px_rgb),
    .out_tlast  (out_tlast)
  );

  assign out_tdata = {2'b00, px_rgb.blue, px_rgb.green, px_rgb.red, px_idx};

  a_no_fire_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> seq_idle)
    else $error("frame fired while the sequencer was busy");

  a_fire_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (elapsed_r == '0))
    else $error("elapsed count not cleared after a frame");

  a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_accept |=> $stable(elapsed_r))
    else $error("elapsed count changed without an input word");

endmodule
